FILE: rtl/dbgrx_pkg.sv
// Shared types, character codes and helper functions for the debug stub packet receiver.
package dbgrx_pkg;

    // Default capacity of the packet text, in bytes.
    localparam int unsigned DBGRX_CMD_CAPACITY = 511;

    // Reset value of the memory read length clamp.
    localparam logic [7:0] DBGRX_MAX_READ_LEN_RST = 8'd128;

    // Hard upper bound on any memory read length.
    localparam logic [7:0] DBGRX_READ_LEN_CAP = 8'd128;

    // Code that marks a character that is not a hex digit.
    localparam logic [7:0] HEX_BAD = 8'hff;

    // Framing and command characters.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_LO_Q   = 8'h71;
    localparam logic [7:0] CH_LO_G   = 8'h67;
    localparam logic [7:0] CH_UP_G   = 8'h47;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_M   = 8'h6d;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_UP_D   = 8'h44;
    localparam logic [7:0] CH_LO_K   = 8'h6b;
    localparam logic [7:0] CH_UP_S   = 8'h53;
    localparam logic [7:0] CH_UP_O   = 8'h4f;

    // Query candidates tracked after the leading 'q'.
    localparam logic [1:0] QRY_NONE      = 2'd0;
    localparam logic [1:0] QRY_SUPPORTED = 2'd1;
    localparam logic [1:0] QRY_OFFSETS   = 2'd2;
    localparam logic [3:0] QRY_SUPPORTED_LEN = 4'd9;
    localparam logic [3:0] QRY_OFFSETS_LEN   = 4'd7;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_TEXT     = 3'd1,
        PH_DIG1     = 3'd2,
        PH_DIG2     = 3'd3,
        PH_WAIT_ACK = 3'd4,
        PH_QUIT     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        TX_NONE   = 2'd0,
        TX_ACK    = 2'd1,
        TX_NAK    = 2'd2,
        TX_RESEND = 2'd3
    } tx_action_t;

    typedef enum logic [3:0] {
        RK_NONE    = 4'd0,
        RK_STOP    = 4'd1,
        RK_OK      = 4'd2,
        RK_EMPTY   = 4'd3,
        RK_OFFSETS = 4'd4,
        RK_REGS    = 4'd5,
        RK_ERROR   = 4'd6,
        RK_MEMREAD = 4'd7,
        RK_QUIT    = 4'd8
    } reply_kind_t;

    typedef struct packed {
        logic        session_over;
        logic [7:0]  mem_length;
        logic [31:0] mem_address;
        reply_kind_t reply_kind;
        tx_action_t  tx_action;
    } dbgrx_result_t;

    // Value of one hex digit, or HEX_BAD for any other character.
    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v;
    endfunction

    // Expected character at position idx of the query word for a candidate.
    function automatic logic [7:0] query_char(input logic [1:0] cand, input logic [3:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (cand == QRY_SUPPORTED) begin
            unique case (idx)
                4'd0:    ch = 8'h53; // S
                4'd1:    ch = 8'h75; // u
                4'd2:    ch = 8'h70; // p
                4'd3:    ch = 8'h70; // p
                4'd4:    ch = 8'h6f; // o
                4'd5:    ch = 8'h72; // r
                4'd6:    ch = 8'h74; // t
                4'd7:    ch = 8'h65; // e
                4'd8:    ch = 8'h64; // d
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (idx)
                4'd0:    ch = 8'h4f; // O
                4'd1:    ch = 8'h66; // f
                4'd2:    ch = 8'h66; // f
                4'd3:    ch = 8'h73; // s
                4'd4:    ch = 8'h65; // e
                4'd5:    ch = 8'h74; // t
                4'd6:    ch = 8'h73; // s
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

FILE: rtl/dbgrx_core.sv
// Packet framing state, checksum check, classification and memory request parsing.
module dbgrx_core
    import dbgrx_pkg::*;
#(
    parameter int unsigned CMD_CAPACITY = DBGRX_CMD_CAPACITY
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    max_read_len,
    output dbgrx_result_t result
);

    localparam int unsigned CNT_W = $clog2(CMD_CAPACITY + 1);

    phase_t             phase_reg,       phase_next;
    logic [7:0]         text_sum_reg,    text_sum_next;
    logic [11:0]        rx_checksum_reg, rx_checksum_next;
    logic [7:0]         first_char_reg,  first_char_next;
    logic [CNT_W-1:0]   text_count_reg,  text_count_next;
    logic               text_ended_reg,  text_ended_next;
    logic [31:0]        addr_acc_reg,    addr_acc_next;
    logic [31:0]        len_acc_reg,     len_acc_next;
    logic               comma_seen_reg,  comma_seen_next;
    logic [1:0]         qry_cand_reg,    qry_cand_next;
    logic [3:0]         qry_cnt_reg,     qry_cnt_next;

    logic [7:0] hv;
    logic [7:0] rx_sum;
    logic       sum_ok;
    logic [3:0] qry_len;
    logic [7:0] len_lim;
    logic [7:0] len_clamped;

    always_comb begin
        hv      = hex_val(rx_byte);
        rx_sum  = {rx_checksum_reg[7:4], hv[3:0]};
        sum_ok  = (hv <= 8'd15) && (rx_checksum_reg <= 12'h0f0);
        qry_len = (qry_cand_reg == QRY_SUPPORTED) ? QRY_SUPPORTED_LEN : QRY_OFFSETS_LEN;
        len_lim = (max_read_len > DBGRX_READ_LEN_CAP) ? DBGRX_READ_LEN_CAP : max_read_len;
        len_clamped = (len_acc_reg > 32'(DBGRX_READ_LEN_CAP)) ? DBGRX_READ_LEN_CAP
                                                               : len_acc_reg[7:0];
        if (len_clamped > len_lim) begin
            len_clamped = len_lim;
        end
    end

    // Next state of the framing and parsing registers.
    always_comb begin
        phase_next       = phase_reg;
        text_sum_next    = text_sum_reg;
        rx_checksum_next = rx_checksum_reg;
        first_char_next  = first_char_reg;
        text_count_next  = text_count_reg;
        text_ended_next  = text_ended_reg;
        addr_acc_next    = addr_acc_reg;
        len_acc_next     = len_acc_reg;
        comma_seen_next  = comma_seen_reg;
        qry_cand_next    = qry_cand_reg;
        qry_cnt_next     = qry_cnt_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == CH_DOLLAR) begin
                    phase_next       = PH_TEXT;
                    text_sum_next    = '0;
                    rx_checksum_next = '0;
                    first_char_next  = '0;
                    text_count_next  = '0;
                    text_ended_next  = 1'b0;
                    addr_acc_next    = '0;
                    len_acc_next     = '0;
                    comma_seen_next  = 1'b0;
                    qry_cand_next    = QRY_NONE;
                    qry_cnt_next     = '0;
                end
            end
            PH_TEXT: begin
                if (rx_byte == CH_HASH) begin
                    phase_next = PH_DIG1;
                end else if (text_count_reg < CNT_W'(CMD_CAPACITY)) begin
                    text_count_next = text_count_reg + CNT_W'(1);
                    if (!text_ended_reg) begin
                        if (rx_byte == 8'h00) begin
                            text_ended_next = 1'b1;
                        end else begin
                            text_sum_next = text_sum_reg + rx_byte;
                            if (text_count_reg == '0) begin
                                first_char_next = rx_byte;
                            end else begin
                                if (text_count_reg == CNT_W'(1)) begin
                                    if (rx_byte == CH_UP_S) begin
                                        qry_cand_next = QRY_SUPPORTED;
                                        qry_cnt_next  = 4'd1;
                                    end else if (rx_byte == CH_UP_O) begin
                                        qry_cand_next = QRY_OFFSETS;
                                        qry_cnt_next  = 4'd1;
                                    end else begin
                                        qry_cand_next = QRY_NONE;
                                        qry_cnt_next  = '0;
                                    end
                                end else if (qry_cand_reg != QRY_NONE) begin
                                    if (qry_cnt_reg < qry_len &&
                                        rx_byte == query_char(qry_cand_reg, qry_cnt_reg)) begin
                                        qry_cnt_next = qry_cnt_reg + 4'd1;
                                    end else begin
                                        qry_cand_next = QRY_NONE;
                                        qry_cnt_next  = '0;
                                    end
                                end
                                if (!comma_seen_reg && rx_byte == CH_COMMA) begin
                                    comma_seen_next = 1'b1;
                                end else if (!comma_seen_reg) begin
                                    addr_acc_next = {addr_acc_reg[27:0], 4'h0} + 32'(hv);
                                end else begin
                                    len_acc_next = {len_acc_reg[27:0], 4'h0} + 32'(hv);
                                end
                            end
                        end
                    end
                end
            end
            PH_DIG1: begin
                rx_checksum_next = {hv, 4'h0};
                phase_next       = PH_DIG2;
            end
            PH_DIG2: begin
                if (sum_ok) begin
                    rx_checksum_next = {4'h0, rx_sum};
                end
                if (!sum_ok || rx_sum != text_sum_reg) begin
                    phase_next = PH_IDLE;
                end else if (first_char_reg == CH_LO_C || first_char_reg == CH_UP_D ||
                             first_char_reg == CH_LO_K) begin
                    phase_next = PH_QUIT;
                end else begin
                    phase_next = PH_WAIT_ACK;
                end
            end
            PH_WAIT_ACK: begin
                if (rx_byte != CH_MINUS) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_QUIT;
            end
        endcase
    end

    // Result item for the byte at hand.
    always_comb begin
        result              = '0;
        result.tx_action    = TX_NONE;
        result.reply_kind   = RK_NONE;
        result.session_over = (phase_next == PH_QUIT);
        unique case (phase_reg)
            PH_DIG2: begin
                if (!sum_ok || rx_sum != text_sum_reg) begin
                    result.tx_action = TX_NAK;
                end else begin
                    result.tx_action = TX_ACK;
                    unique case (first_char_reg)
                        CH_QMARK: result.reply_kind = RK_STOP;
                        CH_UP_H:  result.reply_kind = RK_OK;
                        CH_LO_Q: begin
                            result.reply_kind = (qry_cand_reg == QRY_OFFSETS &&
                                                 qry_cnt_reg == QRY_OFFSETS_LEN)
                                                ? RK_OFFSETS : RK_EMPTY;
                        end
                        CH_LO_G:  result.reply_kind = RK_REGS;
                        CH_UP_G, CH_LO_S: result.reply_kind = RK_ERROR;
                        CH_LO_M: begin
                            result.reply_kind  = RK_MEMREAD;
                            result.mem_address = addr_acc_reg;
                            result.mem_length  = len_clamped;
                        end
                        CH_LO_C, CH_UP_D, CH_LO_K: result.reply_kind = RK_QUIT;
                        default:  result.reply_kind = RK_EMPTY;
                    endcase
                end
            end
            PH_WAIT_ACK: begin
                if (rx_byte == CH_PLUS) begin
                    result.tx_action = TX_NONE;
                end else if (rx_byte == CH_MINUS) begin
                    result.tx_action = TX_RESEND;
                end else begin
                    result.tx_action = TX_NAK;
                end
            end
            default: begin
                result.tx_action = TX_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            text_sum_reg    <= '0;
            rx_checksum_reg <= '0;
            first_char_reg  <= '0;
            text_count_reg  <= '0;
            text_ended_reg  <= 1'b0;
            addr_acc_reg    <= '0;
            len_acc_reg     <= '0;
            comma_seen_reg  <= 1'b0;
            qry_cand_reg    <= QRY_NONE;
            qry_cnt_reg     <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            text_sum_reg    <= text_sum_next;
            rx_checksum_reg <= rx_checksum_next;
            first_char_reg  <= first_char_next;
            text_count_reg  <= text_count_next;
            text_ended_reg  <= text_ended_next;
            addr_acc_reg    <= addr_acc_next;
            len_acc_reg     <= len_acc_next;
            comma_seen_reg  <= comma_seen_next;
            qry_cand_reg    <= qry_cand_next;
            qry_cnt_reg     <= qry_cnt_next;
        end
    end

endmodule

FILE: rtl/debug_stub_packet_receiver.sv
// Top level of the debug stub packet receiver: input register, core and result register.
//
//  Channel  | Direction | Payload                                            | Handshake
//  s_       | in        | s_tdata[7:0] rx_byte                               | s_tvalid/s_tready
//  m_       | out       | m_tdata tx_action, reply_kind, address, length,    | m_tvalid/m_tready
//           |           | session_over                                       |
//  cfg_     | in        | cfg_wdata[7:0] max_read_len                        | cfg_we
//
// Every received item produces exactly one result item, which enters the result
// register at the same edge at which the item leaves the input register, so the
// block sustains one item per clock while m_tready does not stall it; the only
// loop is the update of the framing state in the core.
// An accepted item passes through the input register, then the result register.
// Reset is synchronous and active low; it returns the framer to waiting for a
// packet start and sets the read length clamp to 128.
// A stall on m_tready holds the result register, then the input register, and only
// then drops s_tready, so no item is lost or repeated.
module debug_stub_packet_receiver
    import dbgrx_pkg::*;
#(
    parameter int unsigned CMD_CAPACITY = DBGRX_CMD_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [1:0] tx_action, [5:2] reply_kind, [37:6] mem_address,
                                   // [45:38] mem_length, [46] session_over, [47] zero

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // [7:0] max_read_len
);

    // The read length clamp; the user must write it only while the block is idle, which the block does not enforce.
    logic [7:0] max_read_len_reg;

    // Input register holds one received byte waiting for the core.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result register holds the item offered on the master side.
    logic          out_valid_reg;
    dbgrx_result_t out_result_reg;

    dbgrx_result_t core_result;
    logic          advance;
    logic          step_en;

    // The result register can take a new item when it is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    // The input register can take a byte when it is empty or moving on this cycle.
    assign s_tready = !in_valid_reg || advance;
    // The core updates its state exactly once for each byte that moves to the result.
    assign step_en  = in_valid_reg && advance;

    dbgrx_core #(
        .CMD_CAPACITY (CMD_CAPACITY)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .rx_byte      (in_byte_reg),
        .max_read_len (max_read_len_reg),
        .result       (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_read_len_reg <= DBGRX_MAX_READ_LEN_RST;
        end else if (cfg_we) begin
            max_read_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (step_en) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.session_over,
                       out_result_reg.mem_length,
                       out_result_reg.mem_address,
                       4'(out_result_reg.reply_kind),
                       2'(out_result_reg.tx_action)};

    // A reply kind is only ever reported together with an acknowledge.
    a_kind_with_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result_reg.reply_kind != RK_NONE |->
            out_result_reg.tx_action == TX_ACK)
        else $error("reply kind reported without an acknowledge");

    // Address and length are only nonzero on a memory read, and the length is clamped.
    a_mem_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_result_reg.mem_length <= DBGRX_READ_LEN_CAP) &&
            (out_result_reg.reply_kind == RK_MEMREAD ||
             (out_result_reg.mem_address == '0 && out_result_reg.mem_length == '0)))
        else $error("memory read fields out of place or beyond the clamp");

    // Once the session is over, the next result item reports it again.
    a_quit_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && out_result_reg.session_over |=>
            !m_tvalid || out_result_reg.session_over)
        else $error("session left the quit phase");

    // After a quit the receiver neither acknowledges nor rejects anything.
    a_quit_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result_reg.session_over && out_result_reg.reply_kind != RK_QUIT |->
            out_result_reg.tx_action == TX_NONE)
        else $error("activity reported after the session ended");

endmodule

FILE: tb/sv/debug_stub_packet_receiver_check.sv
// Checker for the debug stub packet receiver: predicts every result item and compares it.
module debug_stub_packet_receiver_check
    import dbgrx_pkg::*;
#(
    parameter int unsigned CAPACITY = DBGRX_CMD_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,    // [1:0] tx_action, [5:2] reply_kind, [37:6] mem_address,
                                    // [45:38] mem_length, [46] session_over, [47] zero
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,  // [7:0] max_read_len
    output int unsigned pending,
    output int unsigned fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        pad;
        logic        session_over;
        logic [7:0]  mem_length;
        logic [31:0] mem_address;
        logic [3:0]  reply_kind;
        logic [1:0]  tx_action;
    } reply_item_t;

    localparam logic [71:0] WORD_SUPPORTED = "Supported";
    localparam logic [55:0] WORD_OFFSETS   = "Offsets";

    reply_item_t replies_due[$];

    // Framer state as the block should hold it.
    logic [7:0]  read_limit;
    phase_t      fr_phase;
    logic [7:0]  fr_sum;
    logic [11:0] fr_digits;
    logic [7:0]  fr_first;
    int unsigned fr_count;
    logic        fr_ended;
    logic [31:0] fr_addr;
    logic [31:0] fr_len;
    logic        fr_comma;
    logic [1:0]  fr_cand;
    logic [3:0]  fr_matched;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - 8'h30;
        if (c >= "A" && c <= "F") return c - 8'h37;
        if (c >= "a" && c <= "f") return c - 8'h57;
        return HEX_BAD;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] cand, input logic [3:0] idx);
        int i;
        i = idx;
        if (cand == QRY_SUPPORTED) return WORD_SUPPORTED[8 * (8 - i) +: 8];
        return WORD_OFFSETS[8 * (6 - i) +: 8];
    endfunction

    function void clear_packet();
        fr_sum     = '0;
        fr_digits  = '0;
        fr_first   = '0;
        fr_count   = 0;
        fr_ended   = 1'b0;
        fr_addr    = '0;
        fr_len     = '0;
        fr_comma   = 1'b0;
        fr_cand    = QRY_NONE;
        fr_matched = '0;
    endfunction

    function void take_text(input logic [7:0] c);
        int unsigned pos;
        logic [3:0]  word_len;
        pos = fr_count;
        if (fr_count >= CAPACITY) return;
        fr_count++;
        if (fr_ended) return;
        if (c == 8'h00) begin
            fr_ended = 1'b1;
            return;
        end
        fr_sum = fr_sum + c;
        if (pos == 0) begin
            fr_first = c;
            return;
        end
        // Track an exact query word starting at the second text byte.
        if (pos == 1) begin
            fr_matched = 4'd1;
            if (c == CH_UP_S) begin
                fr_cand = QRY_SUPPORTED;
            end else if (c == CH_UP_O) begin
                fr_cand = QRY_OFFSETS;
            end else begin
                fr_cand    = QRY_NONE;
                fr_matched = '0;
            end
        end else if (fr_cand != QRY_NONE) begin
            word_len = (fr_cand == QRY_SUPPORTED) ? QRY_SUPPORTED_LEN : QRY_OFFSETS_LEN;
            if (fr_matched < word_len && c == word_char(fr_cand, fr_matched)) begin
                fr_matched = fr_matched + 4'd1;
            end else begin
                fr_cand    = QRY_NONE;
                fr_matched = '0;
            end
        end
        // Memory read arguments: the address up to the first comma, the length after it.
        if (!fr_comma && c == CH_COMMA) begin
            fr_comma = 1'b1;
            return;
        end
        if (!fr_comma) begin
            fr_addr = (fr_addr << 4) + {24'h0, digit_value(c)};
        end else begin
            fr_len = (fr_len << 4) + {24'h0, digit_value(c)};
        end
    endfunction

    function void step_framer(input logic [7:0] c, output reply_item_t r);
        logic [7:0] n;
        logic [7:0] lim;
        logic [7:0] len;
        logic       ok;
        r = '0;
        case (fr_phase)
            PH_IDLE: begin
                if (c == CH_DOLLAR) begin
                    clear_packet();
                    fr_phase = PH_TEXT;
                end
            end
            PH_TEXT: begin
                if (c == CH_HASH) begin
                    fr_phase = PH_DIG1;
                end else begin
                    take_text(c);
                end
            end
            PH_DIG1: begin
                fr_digits = {digit_value(c), 4'h0};
                fr_phase  = PH_DIG2;
            end
            PH_DIG2: begin
                n  = digit_value(c);
                ok = (n <= 8'd15) && (fr_digits <= 12'h0f0);
                if (ok) fr_digits = fr_digits + {4'h0, n};
                if (!ok || fr_digits != {4'h0, fr_sum}) begin
                    r.tx_action = TX_NAK;
                    fr_phase    = PH_IDLE;
                end else begin
                    r.tx_action = TX_ACK;
                    fr_phase    = PH_WAIT_ACK;
                    case (fr_first)
                        CH_QMARK: r.reply_kind = RK_STOP;
                        CH_UP_H:  r.reply_kind = RK_OK;
                        CH_LO_Q: begin
                            if (fr_cand == QRY_OFFSETS && fr_matched == QRY_OFFSETS_LEN) begin
                                r.reply_kind = RK_OFFSETS;
                            end else begin
                                r.reply_kind = RK_EMPTY;
                            end
                        end
                        CH_LO_G:           r.reply_kind = RK_REGS;
                        CH_UP_G, CH_LO_S:  r.reply_kind = RK_ERROR;
                        CH_LO_M: begin
                            lim = (read_limit > DBGRX_READ_LEN_CAP) ? DBGRX_READ_LEN_CAP
                                                                     : read_limit;
                            len = (fr_len > 32'd128) ? DBGRX_READ_LEN_CAP : fr_len[7:0];
                            if (len > lim) len = lim;
                            r.reply_kind  = RK_MEMREAD;
                            r.mem_address = fr_addr;
                            r.mem_length  = len;
                        end
                        CH_LO_C, CH_UP_D, CH_LO_K: begin
                            r.reply_kind = RK_QUIT;
                            fr_phase     = PH_QUIT;
                        end
                        default: r.reply_kind = RK_EMPTY;
                    endcase
                end
            end
            PH_WAIT_ACK: begin
                if (c == CH_PLUS) begin
                    fr_phase = PH_IDLE;
                end else if (c == CH_MINUS) begin
                    r.tx_action = TX_RESEND;
                end else begin
                    r.tx_action = TX_NAK;
                    fr_phase    = PH_IDLE;
                end
            end
            default: fr_phase = PH_QUIT;
        endcase
        r.session_over = (fr_phase >= PH_QUIT);
    endfunction

    function void check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        reply_item_t predicted;
        reply_item_t seen;
        reply_item_t want;
        if (!aresetn) begin
            clear_packet();
            fr_phase   = PH_IDLE;
            read_limit = DBGRX_MAX_READ_LEN_RST;
            replies_due.delete();
        end else begin
            if (cfg_we) read_limit = cfg_wdata;
            if (s_tvalid && s_tready) begin
                step_framer(s_tdata, predicted);
                replies_due.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                seen = m_tdata;
                if (replies_due.size() == 0) begin
                    $error("result item 0x%0h arrived with no item outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("tx_action", 32'(want.tx_action), 32'(seen.tx_action));
                    check_field("reply_kind", 32'(want.reply_kind), 32'(seen.reply_kind));
                    check_field("mem_address", want.mem_address, seen.mem_address);
                    check_field("mem_length", 32'(want.mem_length), 32'(seen.mem_length));
                    check_field("session_over", 32'(want.session_over),
                                32'(seen.session_over));
                    check_field("pad", 32'(want.pad), 32'(seen.pad));
                end
            end
        end
        pending = replies_due.size();
    end

endmodule

FILE: tb/sv/debug_stub_packet_receiver_test.sv
// Top of the debug stub packet receiver test: clock, reset, stimulus and verdict.
module debug_stub_packet_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dbgrx_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // How the checksum digits of a packet are sent.
    typedef enum int unsigned {
        CHK_GOOD,
        CHK_WRONG,
        CHK_BAD_HIGH,
        CHK_BAD_LOW
    } chk_style_t;

    // What follows a packet while the block waits for the acknowledge.
    typedef enum int unsigned {
        ACK_PLUS,
        ACK_RESEND,
        ACK_JUNK,
        ACK_NONE
    } ack_style_t;

    // Shapes of packet text that the random part draws from.
    typedef enum int unsigned {
        TK_STOP,
        TK_THREAD,
        TK_REGS,
        TK_WRITE_REGS,
        TK_STEP,
        TK_SUPPORTED,
        TK_OFFSETS,
        TK_QUERY,
        TK_MEM,
        TK_MEM_BAD,
        TK_EMPTY,
        TK_JUNK,
        TK_QUIT_NAK
    } text_kind_t;

    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned PHASE_BUDGET = 70;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;

    int unsigned pending;
    int unsigned fail_count;

    // Idling controls shared by the sender and the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned items_sent    = 0;

    // A long receiver hold-off is requested by bumping the ticket.
    int unsigned hold_ticket = 0;
    int unsigned hold_taken  = 0;
    int unsigned hold_left   = 0;

    debug_stub_packet_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    debug_stub_packet_receiver_check u_reply_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // The clock runs with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The receiver stalls at random, except during a requested hold-off, when it
    // keeps m_tready low for a long stretch so that the block fills up and pushes
    // back on its input.
    always @(posedge aclk) begin
        if (hold_ticket != hold_taken) begin
            hold_taken = hold_ticket;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one item and return at the edge where it is accepted. An idle gap, if
    // one is drawn, drops tvalid first; otherwise tvalid simply stays high, so the
    // signal gets only one assignment per edge.
    task automatic send_item(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop offering items and wait until every result item has come back and the
    // block is surely idle.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Write the read length clamp. This is only called while the block is idle.
    task automatic set_read_limit(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return 8'h30 + nib;
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // Characters just outside the hex digit ranges, plus a few high bytes.
    function automatic logic [7:0] non_hex();
        case ($urandom_range(7))
            0:       return 8'h2f;
            1:       return 8'h3a;
            2:       return 8'h40;
            3:       return 8'h47;
            4:       return 8'h60;
            5:       return 8'h67;
            6:       return 8'hff;
            default: return 8'h80;
        endcase
    endfunction

    // Any byte that does not end the packet text.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_HASH) b = ~b;
        return b;
    endfunction

    task automatic append_digits(ref byte_q_t q, input int unsigned n);
        repeat (n) q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
    endtask

    task automatic append_string(ref byte_q_t q, input string w);
        foreach (w[i]) q.push_back(w[i]);
    endtask

    // Frame the text as a packet with its checksum, then answer the acknowledge.
    // The checksum covers the text up to the first zero byte and no further than
    // the capacity, just as the block sums it.
    task automatic send_packet(input byte_q_t txt, input chk_style_t chk, input ack_style_t ack);
        logic [7:0] sum;
        logic       ended;
        logic       upper;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] junk;
        sum   = 8'h00;
        ended = 1'b0;
        foreach (txt[i]) begin
            if (i < DBGRX_CMD_CAPACITY && !ended) begin
                if (txt[i] == 8'h00) begin
                    ended = 1'b1;
                end else begin
                    sum = sum + txt[i];
                end
            end
        end
        if (chk == CHK_WRONG) sum = sum ^ (8'h01 << $urandom_range(7));
        upper = 1'($urandom_range(1));
        d1 = hex_char(sum[7:4], upper);
        d2 = hex_char(sum[3:0], upper);
        if (chk == CHK_BAD_HIGH) d1 = non_hex();
        if (chk == CHK_BAD_LOW) d2 = non_hex();

        send_item(CH_DOLLAR);
        foreach (txt[i]) send_item(txt[i]);
        send_item(CH_HASH);
        send_item(d1);
        send_item(d2);

        case (ack)
            ACK_PLUS: send_item(CH_PLUS);
            ACK_RESEND: begin
                repeat ($urandom_range(1, 2)) send_item(CH_MINUS);
                send_item(CH_PLUS);
            end
            ACK_JUNK: begin
                junk = 8'($urandom_range(255));
                if (junk == CH_PLUS || junk == CH_MINUS) junk = 8'h00;
                send_item(junk);
            end
            default: ;
        endcase
    endtask

    // A fixed text, with a zero byte put in at zero_at when that is not negative.
    task automatic send_text(input string s, input int zero_at, input chk_style_t chk,
                             input ack_style_t ack);
        byte_q_t txt;
        append_string(txt, s);
        if (zero_at >= 0) txt.insert(zero_at, 8'h00);
        send_packet(txt, chk, ack);
    endtask

    task automatic make_text(input text_kind_t kind, output byte_q_t txt);
        string      w;
        int unsigned cut;
        logic [7:0] f;
        txt = {};
        case (kind)
            TK_STOP: txt.push_back(CH_QMARK);
            TK_THREAD: begin
                txt.push_back(CH_UP_H);
                txt.push_back($urandom_range(1) ? CH_LO_G : CH_LO_C);
                append_digits(txt, $urandom_range(0, 3));
            end
            TK_REGS: txt.push_back(CH_LO_G);
            TK_WRITE_REGS: begin
                txt.push_back(CH_UP_G);
                append_digits(txt, $urandom_range(0, 16));
            end
            TK_STEP: begin
                txt.push_back(CH_LO_S);
                append_digits(txt, $urandom_range(0, 2));
            end
            TK_SUPPORTED: append_string(txt, "qSupported");
            TK_OFFSETS: append_string(txt, "qOffsets");
            TK_QUERY: begin
                // A prefix of a query word, sometimes with a stray byte after it.
                if ($urandom_range(1)) begin
                    w = "Offsets";
                end else begin
                    w = "Supported";
                end
                cut = $urandom_range(0, w.len());
                txt.push_back(CH_LO_Q);
                for (int i = 0; i < cut; i++) txt.push_back(w[i]);
                if ($urandom_range(1)) txt.push_back(text_byte());
            end
            TK_MEM: begin
                txt.push_back(CH_LO_M);
                append_digits(txt, $urandom_range(1, 8));
                txt.push_back(CH_COMMA);
                append_digits(txt, ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 2));
            end
            TK_MEM_BAD: begin
                // Long addresses, missing or doubled commas and bad digits.
                txt.push_back(CH_LO_M);
                append_digits(txt, $urandom_range(0, 12));
                if ($urandom_range(3) != 0) begin
                    txt.push_back(CH_COMMA);
                    append_digits(txt, $urandom_range(0, 10));
                end
                if ($urandom_range(1)) begin
                    txt.push_back(CH_COMMA);
                    append_digits(txt, $urandom_range(0, 2));
                end
                if (txt.size() > 1 && $urandom_range(1)) begin
                    txt[$urandom_range(1, txt.size() - 1)] = non_hex();
                end
            end
            TK_EMPTY: ;
            TK_JUNK: begin
                // Any leading byte except the ones that would end the session.
                f = text_byte();
                if (f == CH_LO_C || f == CH_UP_D || f == CH_LO_K) f = CH_QMARK;
                txt.push_back(f);
                repeat ($urandom_range(0, 6)) txt.push_back(text_byte());
            end
            default: begin
                // A session-ending command; the caller always spoils its checksum.
                case ($urandom_range(2))
                    0:       txt.push_back(CH_LO_C);
                    1:       txt.push_back(CH_UP_D);
                    default: txt.push_back(CH_LO_K);
                endcase
                append_digits(txt, $urandom_range(0, 4));
            end
        endcase
    endtask

    // Mostly well-formed packets with random content, a share of broken checksums,
    // odd acknowledges, zero bytes inside the text and line noise between packets.
    task automatic send_random_packet();
        byte_q_t     txt;
        text_kind_t  kind;
        chk_style_t  chk;
        ack_style_t  ack;
        int unsigned r;
        logic [7:0]  noise;
        kind = text_kind_t'($urandom_range(TK_STOP, TK_QUIT_NAK));
        make_text(kind, txt);
        if ($urandom_range(99) < 8) begin
            txt.insert($urandom_range(0, txt.size()), 8'h00);
            repeat ($urandom_range(0, 3)) txt.push_back(text_byte());
        end
        chk = ($urandom_range(99) < 80) ? CHK_GOOD : chk_style_t'($urandom_range(1, 3));
        if (kind == TK_QUIT_NAK) chk = chk_style_t'($urandom_range(1, 3));
        r = $urandom_range(99);
        ack = (r < 70) ? ACK_PLUS : (r < 85) ? ACK_RESEND : ACK_JUNK;
        send_packet(txt, chk, ack);
        // Noise between packets never holds a dollar, so it cannot open a packet.
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 3)) begin
                noise = 8'($urandom_range(255));
                if (noise == CH_DOLLAR) noise = CH_PLUS;
                send_item(noise);
            end
        end
    endtask

    initial begin : stimulus
        byte_q_t     txt;
        logic [7:0]  limit;
        int unsigned target;
        int unsigned long_len;

        // Reset is held at the start and released at a clock edge.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed packets with the clamp at its reset value: every command but the
        // session-ending ones, exact and near-miss queries, address wrap, length clamp,
        // a bad address digit and a second comma, empty text, a zero byte in the text,
        // each way to spoil the checksum, a resend request and a junk acknowledge.
        send_text("?", -1, CHK_GOOD, ACK_PLUS);
        send_text("Hg0", -1, CHK_GOOD, ACK_PLUS);
        send_text("g", -1, CHK_GOOD, ACK_RESEND);
        send_text("G0123456789abcdefABCDEF", -1, CHK_GOOD, ACK_PLUS);
        send_text("s", -1, CHK_GOOD, ACK_PLUS);
        send_text("qSupported", -1, CHK_GOOD, ACK_PLUS);
        send_text("qOffsets", -1, CHK_GOOD, ACK_PLUS);
        send_text("qOffset", -1, CHK_GOOD, ACK_PLUS);
        send_text("qOffsetsx", -1, CHK_GOOD, ACK_PLUS);
        send_text("m0,0", -1, CHK_GOOD, ACK_PLUS);
        send_text("mffffffff,ffff", -1, CHK_GOOD, ACK_PLUS);
        send_text("m123456789,81", -1, CHK_GOOD, ACK_PLUS);
        send_text("m12g4,1,0", -1, CHK_GOOD, ACK_PLUS);
        send_text("", -1, CHK_GOOD, ACK_PLUS);
        send_text("m10,20", 3, CHK_GOOD, ACK_PLUS);
        send_text("?", -1, CHK_WRONG, ACK_PLUS);
        send_text("g", -1, CHK_BAD_HIGH, ACK_PLUS);
        send_text("H", -1, CHK_BAD_LOW, ACK_JUNK);
        send_text("qC", -1, CHK_GOOD, ACK_JUNK);
        send_text("x", -1, CHK_GOOD, ACK_PLUS);
        wait_for_replies();

        // Random phases, each with its own idling pattern and clamp setting.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    limit         = DBGRX_MAX_READ_LEN_RST;
                end
                1: begin
                    send_idle_pct = 80;
                    stall_pct     = 0;
                    limit         = 8'd1;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 80;
                    limit         = 8'd0;
                end
                3: begin
                    send_idle_pct = 10;
                    stall_pct     = 10;
                    limit         = 8'($urandom_range(2, 127));
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    limit         = 8'hff;
                end
            endcase
            set_read_limit(limit);

            if (ph == 0) begin
                // The receiver holds off while the sender keeps offering a packet
                // longer than the text capacity, so the input side must stall and
                // the bytes past the capacity must be dropped.
                hold_ticket++;
                txt = {};
                case ($urandom_range(2))
                    0:       txt.push_back(CH_LO_M);
                    1:       txt.push_back(CH_LO_Q);
                    default: txt.push_back(CH_QMARK);
                endcase
                long_len = $urandom_range(DBGRX_CMD_CAPACITY + 1, DBGRX_CMD_CAPACITY + 20);
                while (txt.size() < long_len) begin
                    txt.push_back($urandom_range(1) ? hex_char(4'($urandom_range(15)), 1'b0)
                                                    : text_byte());
                end
                send_packet(txt, CHK_GOOD, ACK_PLUS);
            end

            target = items_sent + PHASE_BUDGET;
            while (items_sent < target) send_random_packet();
            wait_for_replies();
        end

        // The session ends last, since nothing leaves the quit phase but reset.
        // The bytes after it must all be absorbed.
        case ($urandom_range(2))
            0:       send_text("c", -1, CHK_GOOD, ACK_NONE);
            1:       send_text("D", -1, CHK_GOOD, ACK_NONE);
            default: send_text("k", -1, CHK_GOOD, ACK_NONE);
        endcase
        send_item(CH_DOLLAR);
        send_item(CH_PLUS);
        repeat (6) send_item(8'($urandom_range(255)));
        wait_for_replies();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // A hung handshake ends the run long after the slowest correct run would.
    initial begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
